>>> rtl/min_sad_basis_search_unit_macros.svh
// Assertion helpers for the search unit; clock clk, reset rst_n assumed in scope.
`ifndef MIN_SAD_BASIS_SEARCH_UNIT_MACROS_SVH
`define MIN_SAD_BASIS_SEARCH_UNIT_MACROS_SVH

// same-cycle implication
`define MSBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/msbs_pkg.sv
`timescale 1ns / 1ps
package msbs_pkg;

    localparam int SLOT_W     = 3;
    localparam int SIDX_W     = 6;
    localparam int SUM_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int FIFO_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFF  = 1'd1;

    localparam logic       KIND_LOAD  = 1'b0;
    localparam logic       KIND_BASIS = 1'b1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic add_en;
        logic end_point;
        logic end_search;
    } ctl_t;

endpackage

>>> rtl/msbs_front.sv
`timescale 1ns / 1ps
module msbs_front #(
    parameter int SLOTS       = 5,
    parameter int SAMPLES     = 50,
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         kind,
    input  logic [msbs_pkg::SLOT_W-1:0]  slot,
    input  logic [msbs_pkg::SIDX_W-1:0]  sample_index,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    input  logic [INDEX_BITS-1:0]        candidate_index,
    input  logic                         last_of_point,
    input  logic                         last_of_search,
    input  logic [SLOTS-1:0]             slot_mask,
    output logic                         q_push,
    output msbs_pkg::ctl_t               q_ctl,
    output logic [SAMPLE_BITS:0]         q_diff,
    output logic [INDEX_BITS-1:0]        q_cand,
    output logic                         busy
);

    localparam int ENTRIES = SLOTS * SAMPLES;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DW      = SAMPLE_BITS + 1;

    logic [SAMPLE_BITS-1:0] mem [ENTRIES];

    logic [AW-1:0]          addr;
    logic                   in_range;
    logic [SLOTS-1:0]       mask_sh;
    logic                   wr_en;
    logic                   rd_en;

    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [SAMPLE_BITS-1:0] s1_val_reg;
    msbs_pkg::ctl_t         s1_ctl_reg;
    logic [INDEX_BITS-1:0]  s1_cand_reg;

    logic signed [DW-1:0]   diff;

    assign in_range = (32'(slot) < SLOTS) && (32'(sample_index) < SAMPLES);
    assign addr     = AW'(32'(slot) * SAMPLES + 32'(sample_index));
    assign mask_sh  = slot_mask >> slot;
    assign wr_en    = accept && (kind == msbs_pkg::KIND_LOAD) && in_range;
    assign rd_en    = accept && (kind == msbs_pkg::KIND_BASIS);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= sample_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_val_reg            <= sample_value;
            s1_cand_reg           <= candidate_index;
            s1_ctl_reg.add_en     <= in_range && mask_sh[0];
            s1_ctl_reg.end_point  <= last_of_point;
            s1_ctl_reg.end_search <= last_of_search;
        end
    end

    // stored minus basis, one bit wider so it cannot wrap
    assign diff = $signed({rd_data_reg[SAMPLE_BITS-1], rd_data_reg})
                - $signed({s1_val_reg[SAMPLE_BITS-1], s1_val_reg});

    assign q_push = s1_valid_reg;
    assign q_ctl  = s1_ctl_reg;
    assign q_diff = diff[DW-1] ? DW'(-diff) : DW'(diff);
    assign q_cand = s1_cand_reg;
    assign busy   = s1_valid_reg;

endmodule

>>> rtl/msbs_fifo.sv
`timescale 1ns / 1ps
`include "min_sad_basis_search_unit_macros.svh"
module msbs_fifo #(
    parameter int W = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  logic [W-1:0]                          wdata,
    input  logic                                  pop,
    output logic [W-1:0]                          rdata,
    output logic                                  not_empty,
    output logic [$clog2(msbs_pkg::FIFO_DEPTH):0] level
);

    localparam int PW = $clog2(msbs_pkg::FIFO_DEPTH);
    localparam int LW = PW + 1;

    logic [W-1:0]  buf_q [msbs_pkg::FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [LW-1:0] level_reg;
    logic [LW-1:0] level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_q[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata     = buf_q[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

    `MSBS_ASSERT_NOW(a_no_overflow, push && !pop, level_reg != LW'(msbs_pkg::FIFO_DEPTH), "queue overflow")
    `MSBS_ASSERT_NOW(a_no_underflow, pop, level_reg != '0, "queue underflow")

endmodule

>>> rtl/msbs_back.sv
`timescale 1ns / 1ps
`include "min_sad_basis_search_unit_macros.svh"
module msbs_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  msbs_pkg::ctl_t              q_ctl,
    input  logic [SAMPLE_BITS:0]        q_diff,
    input  logic [INDEX_BITS-1:0]       q_cand,
    output logic                        q_pop,
    input  logic [msbs_pkg::SUM_W-1:0]  max_diff,
    input  logic                        res_pop,
    output logic                        res_valid,
    output logic                        res_found,
    output logic [INDEX_BITS-1:0]       res_index,
    output logic [msbs_pkg::SUM_W-1:0]  res_distance
);

    localparam int SW = msbs_pkg::SUM_W;
    localparam int DW = SAMPLE_BITS + 1;
    localparam int EW = ((DW > SW) ? DW : SW) + 1;

    logic [SW-1:0]         run_sum_reg;
    logic [SW-1:0]         run_sum_next;
    logic [SW-1:0]         best_sum_reg;
    logic [SW-1:0]         best_sum_next;
    logic [INDEX_BITS-1:0] best_pt_reg;
    logic [INDEX_BITS-1:0] best_pt_next;
    logic                  have_best_reg;
    logic                  have_best_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  found_reg;
    logic [INDEX_BITS-1:0] index_reg;
    logic [SW-1:0]         dist_reg;

    logic                  fire;
    logic                  emit;
    logic [EW-1:0]         sum_ext;
    logic [SW-1:0]         sum_acc;
    logic                  closes;
    logic                  wins;
    logic [SW-1:0]         cb_sum;
    logic [INDEX_BITS-1:0] cb_pt;
    logic                  cb_have;

    // a search-ending beat needs the result register free (or draining)
    assign fire = q_valid && (!q_ctl.end_search || !out_valid_reg || res_pop);
    assign emit = fire && q_ctl.end_search;
    assign q_pop = fire;

    assign sum_ext = EW'(run_sum_reg) + EW'(q_diff);
    always_comb
    begin
        if (!q_ctl.add_en)
        begin
            sum_acc = run_sum_reg;
        end
        else if (sum_ext > EW'(msbs_pkg::SUM_MAX))
        begin
            sum_acc = msbs_pkg::SUM_MAX;
        end
        else
        begin
            sum_acc = sum_ext[SW-1:0];
        end
    end

    assign closes = q_ctl.end_point || q_ctl.end_search;
    // strict compare keeps the first of equal sums
    assign wins   = (sum_acc < max_diff) && (sum_acc < best_sum_reg);

    always_comb
    begin
        cb_sum  = best_sum_reg;
        cb_pt   = best_pt_reg;
        cb_have = have_best_reg;
        if (closes && wins)
        begin
            cb_sum  = sum_acc;
            cb_pt   = q_cand;
            cb_have = 1'b1;
        end
    end

    always_comb
    begin
        run_sum_next   = run_sum_reg;
        best_sum_next  = best_sum_reg;
        best_pt_next   = best_pt_reg;
        have_best_next = have_best_reg;
        if (fire)
        begin
            run_sum_next   = closes ? '0 : sum_acc;
            best_sum_next  = cb_sum;
            best_pt_next   = cb_pt;
            have_best_next = cb_have;
            if (q_ctl.end_search)
            begin
                best_sum_next  = msbs_pkg::SUM_MAX;
                best_pt_next   = '0;
                have_best_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sum_reg   <= '0;
            best_sum_reg  <= msbs_pkg::SUM_MAX;
            best_pt_reg   <= '0;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_sum_reg   <= run_sum_next;
            best_sum_reg  <= best_sum_next;
            best_pt_reg   <= best_pt_next;
            have_best_reg <= have_best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg <= cb_have;
            index_reg <= cb_have ? cb_pt : '0;
            dist_reg  <= cb_have ? cb_sum : '0;
        end
    end

    assign res_valid    = out_valid_reg;
    assign res_found    = found_reg;
    assign res_index    = index_reg;
    assign res_distance = dist_reg;

    `MSBS_ASSERT_NOW(a_no_best_is_max, !have_best_reg, best_sum_reg == msbs_pkg::SUM_MAX, "best not cleared")
    `MSBS_ASSERT_NEXT(a_sum_clears, fire && closes, run_sum_reg == '0, "running sum kept")
    `MSBS_ASSERT_NOW(a_best_below_limit, have_best_reg, best_sum_reg != msbs_pkg::SUM_MAX, "saturated best")

endmodule

>>> rtl/min_sad_basis_search_unit.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle, loads and basis samples alike, while the result side drains.
// A result shows (empty falls) once the accepted search-ending beat has passed the store read into
// the stage register, the queue write, then the accumulate/compare step that pops it.
// A search end stalls in the back end only while the previous result is still not popped.
// Reset: async active low; clears control, sums and best; slot_mask and max_diff to all ones.
// Sample store contents are undefined until loaded; no clearing pass.
module min_sad_basis_search_unit #(
    parameter int SLOTS       = 5,
    parameter int SAMPLES     = 50,
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             kind,
    input  logic [msbs_pkg::SLOT_W-1:0]      slot,
    input  logic [msbs_pkg::SIDX_W-1:0]      sample_index,
    input  logic signed [SAMPLE_BITS-1:0]    sample_value,
    input  logic [INDEX_BITS-1:0]            candidate_index,
    input  logic                             last_of_point,
    input  logic                             last_of_search,
    output logic                             empty,
    input  logic                             pop,
    output logic                             found,
    output logic [INDEX_BITS-1:0]            best_index,
    output logic [msbs_pkg::SUM_W-1:0]       best_distance,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [msbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msbs_pkg::SUM_W-1:0]       cfg_data
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int QW = 3 + DW + INDEX_BITS;
    localparam int LW = $clog2(msbs_pkg::FIFO_DEPTH) + 1;

    logic [SLOTS-1:0]          slot_mask_reg;
    logic [msbs_pkg::SUM_W-1:0] max_diff_reg;

    logic                      accept;
    logic                      f_push;
    msbs_pkg::ctl_t            f_ctl;
    logic [DW-1:0]             f_diff;
    logic [INDEX_BITS-1:0]     f_cand;
    logic                      f_busy;

    logic [QW-1:0]             q_wdata;
    logic [QW-1:0]             q_rdata;
    logic                      q_valid;
    logic                      q_pop;
    logic [LW-1:0]             q_level;
    msbs_pkg::ctl_t            b_ctl;
    logic [DW-1:0]             b_diff;
    logic [INDEX_BITS-1:0]     b_cand;
    logic                      res_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_mask_reg <= '1;
            max_diff_reg  <= msbs_pkg::SUM_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                msbs_pkg::REG_SLOT_MASK: slot_mask_reg <= cfg_data[SLOTS-1:0];
                msbs_pkg::REG_MAX_DIFF:  max_diff_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // room for the beat in the read stage plus a new one
    assign full   = (LW'(32'(q_level) + 32'(f_busy)) >= LW'(msbs_pkg::FIFO_DEPTH));
    assign accept = push && !full;

    msbs_front #(
        .SLOTS       (SLOTS),
        .SAMPLES     (SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .kind            (kind),
        .slot            (slot),
        .sample_index    (sample_index),
        .sample_value    (sample_value),
        .candidate_index (candidate_index),
        .last_of_point   (last_of_point),
        .last_of_search  (last_of_search),
        .slot_mask       (slot_mask_reg),
        .q_push          (f_push),
        .q_ctl           (f_ctl),
        .q_diff          (f_diff),
        .q_cand          (f_cand),
        .busy            (f_busy)
    );

    assign q_wdata = {f_ctl, f_diff, f_cand};

    msbs_fifo #(
        .W (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_valid),
        .level     (q_level)
    );

    assign {b_ctl, b_diff, b_cand} = q_rdata;

    msbs_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ctl        (b_ctl),
        .q_diff       (b_diff),
        .q_cand       (b_cand),
        .q_pop        (q_pop),
        .max_diff     (max_diff_reg),
        .res_pop      (pop && res_valid),
        .res_valid    (res_valid),
        .res_found    (found),
        .res_index    (best_index),
        .res_distance (best_distance)
    );

    assign empty = !res_valid;

endmodule
